/* hw/rtl/tfj_pkg.sv */
// Shared types, limits and codes for the TLV8 fragment-join decoder.
// No dependencies; imported by every module of the block.
package tfj_pkg;

   localparam int MAX_FIELDS        = 64;
   localparam int MAX_MESSAGE_BYTES = 4096;

   // Wire length saturates one past the limit
   localparam int WL_W  = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam int FC_W  = 7;
   localparam int AR_W  = 13;

   localparam logic [WL_W-1:0] MAX_WL   = WL_W'(MAX_MESSAGE_BYTES);
   localparam logic [FC_W-1:0] MAX_FLDS = FC_W'(MAX_FIELDS);

   // Status codes; ST_OK also means "no error recorded"
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;

   // Event codes
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_OPEN = 2'd1;
   localparam logic [1:0] EV_DATA = 2'd2;

   // Parser phases
   localparam logic [1:0] PH_TYPE   = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_VALUE  = 2'd2;

   localparam logic [7:0] TYPE_SEP  = 8'd255;
   localparam logic [7:0] LEN_FULL  = 8'd255;
   localparam logic [8:0] NO_TYPE   = 9'd256;

   // Register indexes
   localparam logic CSR_ITEM_CAP  = 1'b0;
   localparam logic CSR_ARENA_CAP = 1'b1;

   localparam logic [FC_W-1:0] ITEM_CAP_RST  = 7'd64;
   localparam logic [AR_W-1:0] ARENA_CAP_RST = 13'd4096;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       byte_valid;
      logic       end_of_message;
   } item_type;

   typedef struct packed {
      logic [FC_W-1:0] item_capacity;
      logic [AR_W-1:0] arena_capacity;
   } cfg_type;

   typedef struct packed {
      logic            have;
      logic [1:0]      event_res;
      logic [5:0]      field_index;
      logic [7:0]      field_type;
      logic [7:0]      data_byte;
      logic [11:0]     arena_offset;
      logic            done_res;
      logic [1:0]      status;
      logic [FC_W-1:0] field_count;
   } res_type;

endpackage

/* hw/rtl/tfj_csr.sv */
// Capacity registers of the TLV8 fragment-join decoder.
// Depends on tfj_pkg for register indexes and reset values.
module tfj_csr
   import tfj_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [AR_W-1:0] csr_data,
   output cfg_type         cfg
);

   logic [FC_W-1:0] item_cap_ff,  item_cap_in;
   logic [AR_W-1:0] arena_cap_ff, arena_cap_in;

   assign csr_ready = 1'b1;

   always_comb begin
      item_cap_in  = item_cap_ff;
      arena_cap_in = arena_cap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ITEM_CAP:  item_cap_in  = csr_data[FC_W-1:0];
            CSR_ARENA_CAP: arena_cap_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_cap_ff  <= ITEM_CAP_RST;
         arena_cap_ff <= ARENA_CAP_RST;
      end else begin
         item_cap_ff  <= item_cap_in;
         arena_cap_ff <= arena_cap_in;
      end
   end

   assign cfg.item_capacity  = item_cap_ff;
   assign cfg.arena_capacity = arena_cap_ff;

endmodule

/* hw/rtl/tfj_parse.sv */
// Message state and combinational parse of one item for the TLV8 decoder.
// Depends on tfj_pkg for codes, limits and the item/result structs.
module tfj_parse
   import tfj_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_fire,
   input  item_type item,
   input  cfg_type  cfg,
   output res_type  res
);

   logic [1:0]      phase_ff,       phase_in;
   logic [7:0]      cur_type_ff,    cur_type_in;
   logic [7:0]      bytes_rem_ff,   bytes_rem_in;
   logic [8:0]      prev_type_ff,   prev_type_in;
   logic [7:0]      prev_len_ff,    prev_len_in;
   logic [FC_W-1:0] fields_ff,      fields_in;
   logic [AR_W-1:0] arena_used_ff,  arena_used_in;
   logic [WL_W-1:0] wire_len_ff,    wire_len_in;
   logic [1:0]      first_err_ff,   first_err_in;
   logic [1:0]      pending_err_ff, pending_err_in;

   logic            join_rec;
   logic            opened;
   logic [1:0]      pending_v;
   logic [FC_W-1:0] icap;
   logic [AR_W-1:0] room;
   logic [FC_W-1:0] fields_dec;
   logic [1:0]      status_v;

   assign icap       = (cfg.item_capacity > MAX_FLDS) ? MAX_FLDS : cfg.item_capacity;
   assign room       = (arena_used_ff >= cfg.arena_capacity) ? '0
                                                             : cfg.arena_capacity - arena_used_ff;
   assign join_rec   = ({1'b0, cur_type_ff} == prev_type_ff) && (prev_len_ff == LEN_FULL);
   assign fields_dec = fields_ff - FC_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      cur_type_in    = cur_type_ff;
      bytes_rem_in   = bytes_rem_ff;
      prev_type_in   = prev_type_ff;
      prev_len_in    = prev_len_ff;
      fields_in      = fields_ff;
      arena_used_in  = arena_used_ff;
      wire_len_in    = wire_len_ff;
      first_err_in   = first_err_ff;
      pending_err_in = pending_err_ff;
      pending_v      = pending_err_ff;
      opened         = 1'b0;
      status_v       = ST_OK;
      res            = '0;

      if (item_fire) begin
         if (item.byte_valid) begin
            if (wire_len_ff <= MAX_WL) wire_len_in = wire_len_ff + WL_W'(1);
            // bytes past the length limit or after an error are counted only
            if ((wire_len_in <= MAX_WL) && (first_err_ff == ST_OK)) begin
               unique case (phase_ff)
                  PH_TYPE: begin
                     cur_type_in = item.wire_byte;
                     phase_in    = PH_LENGTH;
                  end
                  PH_LENGTH: begin
                     if (cur_type_ff == TYPE_SEP) begin
                        if (item.wire_byte != 8'd0) begin
                           first_err_in = ST_INVALID;
                        end else begin
                           prev_type_in = NO_TYPE;
                           prev_len_in  = 8'd0;
                           phase_in     = PH_TYPE;
                        end
                     end else begin
                        if (!join_rec && (fields_ff >= icap)) begin
                           pending_v = ST_NO_SPACE;
                        end else if ({5'd0, item.wire_byte} > room) begin
                           pending_v = ST_NO_SPACE;
                        end else if (!join_rec) begin
                           fields_in = fields_ff + FC_W'(1);
                           opened    = 1'b1;
                        end
                        prev_type_in = {1'b0, cur_type_ff};
                        prev_len_in  = item.wire_byte;
                        bytes_rem_in = item.wire_byte;
                        if (item.wire_byte == 8'd0) begin
                           // empty record closes at once; promote pending error
                           phase_in       = PH_TYPE;
                           if (pending_v != ST_OK) first_err_in = pending_v;
                           pending_err_in = ST_OK;
                        end else begin
                           phase_in       = PH_VALUE;
                           pending_err_in = pending_v;
                        end
                        if (opened) begin
                           res.have        = 1'b1;
                           res.event_res   = EV_OPEN;
                           res.field_index = fields_ff[5:0];
                           res.field_type  = cur_type_ff;
                        end
                     end
                  end
                  PH_VALUE: begin
                     if (pending_err_ff == ST_OK) begin
                        res.have         = 1'b1;
                        res.event_res    = EV_DATA;
                        res.field_index  = fields_dec[5:0];
                        res.field_type   = cur_type_ff;
                        res.data_byte    = item.wire_byte;
                        res.arena_offset = arena_used_ff[11:0];
                        arena_used_in    = arena_used_ff + AR_W'(1);
                     end
                     bytes_rem_in = bytes_rem_ff - 8'd1;
                     if (bytes_rem_in == 8'd0) begin
                        phase_in       = PH_TYPE;
                        if (pending_err_ff != ST_OK) first_err_in = pending_err_ff;
                        pending_err_in = ST_OK;
                     end
                  end
                  default: phase_in = PH_TYPE;
               endcase
            end
         end

         if (item.end_of_message) begin
            if (wire_len_in > MAX_WL)         status_v = ST_NO_SPACE;
            else if (first_err_in != ST_OK)   status_v = first_err_in;
            else if (phase_in != PH_TYPE)     status_v = ST_INVALID;
            else                              status_v = ST_OK;
            res.have        = 1'b1;
            res.done_res    = 1'b1;
            res.status      = status_v;
            res.field_count = (status_v == ST_OK) ? fields_in : '0;
            // drop all message state
            phase_in       = PH_TYPE;
            cur_type_in    = 8'd0;
            bytes_rem_in   = 8'd0;
            prev_type_in   = NO_TYPE;
            prev_len_in    = 8'd0;
            fields_in      = '0;
            arena_used_in  = '0;
            wire_len_in    = '0;
            first_err_in   = ST_OK;
            pending_err_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TYPE;
         cur_type_ff    <= 8'd0;
         bytes_rem_ff   <= 8'd0;
         prev_type_ff   <= NO_TYPE;
         prev_len_ff    <= 8'd0;
         fields_ff      <= '0;
         arena_used_ff  <= '0;
         wire_len_ff    <= '0;
         first_err_ff   <= ST_OK;
         pending_err_ff <= ST_OK;
      end else begin
         phase_ff       <= phase_in;
         cur_type_ff    <= cur_type_in;
         bytes_rem_ff   <= bytes_rem_in;
         prev_type_ff   <= prev_type_in;
         prev_len_ff    <= prev_len_in;
         fields_ff      <= fields_in;
         arena_used_ff  <= arena_used_in;
         wire_len_ff    <= wire_len_in;
         first_err_ff   <= first_err_in;
         pending_err_ff <= pending_err_in;
      end
   end

endmodule

/* hw/rtl/tlv8_fragment_join_decoder_core.sv */
// Top level of the TLV8 fragment-join decoder: input register, parser, result register.
// Depends on tfj_pkg, tfj_csr and tfj_parse.
// Usage:
//   req_* carries one item per accepted cycle: a message byte (req_byte_valid high)
//   and/or the end-of-message mark. An item is taken when req_valid is high and
//   req_stall is low. rsp_* carries at most one result per item: a field-open or
//   data event, or the end-of-message status with the field count.
//   csr_* writes item_capacity (index 0) or arena_capacity (index 1); csr_ready
//   is always high. Write only while no message item is in flight.
// Timing:
//   An accepted item is held in the input register and parsed from there once the
//   result register is free or being drained; its result is then registered and
//   driven on rsp_*. One item per cycle is sustained while no result is stalled;
//   the byte parse is the single combinational stage between the two registers.
// Stall:
//   While rsp_stall holds a result, the parser stops and the input register
//   holds its item; req_stall rises only when that register is full and blocked.
// Reset:
//   Synchronous reset empties both registers, clears the message state and sets
//   the capacities to 64 fields and 4096 bytes.
module tlv8_fragment_join_decoder_core
   import tfj_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_wire_byte,
   input  logic            req_byte_valid,
   input  logic            req_end_of_message,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_event_res,
   output logic [5:0]      rsp_field_index,
   output logic [7:0]      rsp_field_type,
   output logic [7:0]      rsp_data_byte,
   output logic [11:0]     rsp_arena_offset,
   output logic            rsp_done_res,
   output logic [1:0]      rsp_status,
   output logic [FC_W-1:0] rsp_field_count,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [AR_W-1:0] csr_data
);

   cfg_type  cfg;
   item_type s1_item_ff, s1_item_in;
   logic     s1_valid_ff, s1_valid_in;
   res_type  parse_res;
   res_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     advance;
   logic     req_take;

   tfj_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tfj_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (s1_item_ff),
      .cfg       (cfg),
      .res       (parse_res)
   );

   // parse whenever the result register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !advance);
      s1_item_in  = s1_item_ff;
      if (req_take) begin
         s1_item_in.wire_byte      = req_wire_byte;
         s1_item_in.byte_valid     = req_byte_valid;
         s1_item_in.end_of_message = req_end_of_message;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (advance && parse_res.have) begin
         rsp_valid_in = 1'b1;
         rsp_in       = parse_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ff.event_res;
   assign rsp_field_index  = rsp_ff.field_index;
   assign rsp_field_type   = rsp_ff.field_type;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_arena_offset = rsp_ff.arena_offset;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_status       = rsp_ff.status;
   assign rsp_field_count  = rsp_ff.field_count;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result was dropped");

   a_result_meaningful: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res != EV_NONE) || rsp_done_res)
      else $error("result carries neither an event nor a status");

   a_no_parse_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !advance)
      else $error("parser advanced while the result register was blocked");
`endif

endmodule

/* bench/tb_tlv8_fragment_join_decoder_core.sv */
`timescale 1ns / 100ps
// Self-checking bench for tlv8_fragment_join_decoder_core: sends TLV8 messages and
// capacity writes, predicts every field/data event and end-of-message status.
// Depends on tfj_pkg and the decoder core RTL.
module tb_tlv8_fragment_join_decoder_core;
   import tfj_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int ITEMS_PER_SLICE = 63;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct packed {
      logic [1:0]      event_res;
      logic [5:0]      field_index;
      logic [7:0]      field_type;
      logic [7:0]      data_byte;
      logic [11:0]     arena_offset;
      logic            done_res;
      logic [1:0]      status;
      logic [FC_W-1:0] field_count;
   } tlv_result_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [7:0]      req_wire_byte = 8'd0;
   logic            req_byte_valid = 1'b0;
   logic            req_end_of_message = 1'b0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [1:0]      rsp_event_res;
   logic [5:0]      rsp_field_index;
   logic [7:0]      rsp_field_type;
   logic [7:0]      rsp_data_byte;
   logic [11:0]     rsp_arena_offset;
   logic            rsp_done_res;
   logic [1:0]      rsp_status;
   logic [FC_W-1:0] rsp_field_count;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic            csr_index = CSR_ITEM_CAP;
   logic [AR_W-1:0] csr_data = '0;

   tlv8_fragment_join_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_wire_byte      (req_wire_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_field_index    (rsp_field_index),
      .rsp_field_type     (rsp_field_type),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_arena_offset   (rsp_arena_offset),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status),
      .rsp_field_count    (rsp_field_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   tlv_result_type tlv_results_q[$];
   int             err_count = 0;
   int             items_sent = 0;
   int             gap_pct = 0;
   int             stall_pct = 0;
   int             quiet_cycles = 0;

   // Decoder state as the block should hold it
   logic [1:0] msg_phase;
   logic [7:0] cur_type;
   logic [7:0] bytes_left;
   logic [8:0] prev_type;
   logic [7:0] prev_len;
   int         fields_seen;
   int         arena_used;
   int         wire_len;
   logic [1:0] first_err;
   logic [1:0] pending_err;
   int         item_cap = ITEM_CAP_RST;
   int         arena_cap = ARENA_CAP_RST;

   function automatic void clear_message();
      msg_phase   = PH_TYPE;
      cur_type    = 8'd0;
      bytes_left  = 8'd0;
      prev_type   = NO_TYPE;
      prev_len    = 8'd0;
      fields_seen = 0;
      arena_used  = 0;
      wire_len    = 0;
      first_err   = ST_OK;
      pending_err = ST_OK;
   endfunction

   // Promote a held capacity error once its record has fully arrived
   function automatic void close_record();
      msg_phase = PH_TYPE;
      if (pending_err != ST_OK && first_err == ST_OK) first_err = pending_err;
      pending_err = ST_OK;
   endfunction

   function automatic void decode_item(input logic [7:0] b, input logic bv, input logic eom);
      tlv_result_type r;
      bit             hit;
      bit             join_rec;
      bit             opened;
      int             icap;
      int             room;
      logic [1:0]     st;
      r   = '0;
      hit = 1'b0;
      if (bv) begin
         if (wire_len <= MAX_MESSAGE_BYTES) wire_len++;
         if (wire_len <= MAX_MESSAGE_BYTES && first_err == ST_OK) begin
            case (msg_phase)
               PH_TYPE: begin
                  cur_type  = b;
                  msg_phase = PH_LENGTH;
               end
               PH_LENGTH: begin
                  if (cur_type == TYPE_SEP) begin
                     if (b != 8'd0) begin
                        first_err = ST_INVALID;
                     end else begin
                        prev_type = NO_TYPE;
                        prev_len  = 8'd0;
                        msg_phase = PH_TYPE;
                     end
                  end else begin
                     join_rec = (prev_type == {1'b0, cur_type}) && (prev_len == LEN_FULL);
                     icap     = (item_cap > MAX_FIELDS) ? MAX_FIELDS : item_cap;
                     room     = (arena_used >= arena_cap) ? 0 : arena_cap - arena_used;
                     opened   = 1'b0;
                     if (!join_rec && fields_seen >= icap) begin
                        pending_err = ST_NO_SPACE;
                     end else if (int'(b) > room) begin
                        pending_err = ST_NO_SPACE;
                     end else if (!join_rec) begin
                        fields_seen++;
                        opened = 1'b1;
                     end
                     prev_type  = {1'b0, cur_type};
                     prev_len   = b;
                     bytes_left = b;
                     if (b == 8'd0) close_record();
                     else msg_phase = PH_VALUE;
                     if (opened) begin
                        r.event_res   = EV_OPEN;
                        r.field_index = 6'(fields_seen - 1);
                        r.field_type  = cur_type;
                        hit = 1'b1;
                     end
                  end
               end
               default: begin
                  if (pending_err == ST_OK) begin
                     r.event_res    = EV_DATA;
                     r.field_index  = 6'(fields_seen - 1);
                     r.field_type   = cur_type;
                     r.data_byte    = b;
                     r.arena_offset = 12'(arena_used);
                     arena_used++;
                     hit = 1'b1;
                  end
                  bytes_left = bytes_left - 8'd1;
                  if (bytes_left == 8'd0) close_record();
               end
            endcase
         end
      end
      if (eom) begin
         if (wire_len > MAX_MESSAGE_BYTES) st = ST_NO_SPACE;
         else if (first_err != ST_OK) st = first_err;
         else if (msg_phase != PH_TYPE) st = ST_INVALID;
         else st = ST_OK;
         r.done_res    = 1'b1;
         r.status      = st;
         r.field_count = (st == ST_OK) ? FC_W'(fields_seen) : '0;
         clear_message();
         hit = 1'b1;
      end
      if (hit) tlv_results_q.push_back(r);
   endfunction

   // Receiver backpressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic report(input string what, input tlv_result_type want,
                         input tlv_result_type got);
      err_count++;
      if (err_count <= 10)
         $display("%s exp ev=%0d idx=%0d typ=%0d dat=%0d off=%0d done=%0d st=%0d cnt=%0d",
                  what, want.event_res, want.field_index, want.field_type, want.data_byte,
                  want.arena_offset, want.done_res, want.status, want.field_count,
                  " | got ev=%0d idx=%0d typ=%0d dat=%0d off=%0d done=%0d st=%0d cnt=%0d",
                  got.event_res, got.field_index, got.field_type, got.data_byte,
                  got.arena_offset, got.done_res, got.status, got.field_count);
   endtask

   always @(posedge clock) begin
      tlv_result_type got;
      tlv_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.event_res    = rsp_event_res;
         got.field_index  = rsp_field_index;
         got.field_type   = rsp_field_type;
         got.data_byte    = rsp_data_byte;
         got.arena_offset = rsp_arena_offset;
         got.done_res     = rsp_done_res;
         got.status       = rsp_status;
         got.field_count  = rsp_field_count;
         if (tlv_results_q.size() == 0) begin
            report("unexpected result:", '0, got);
         end else begin
            want = tlv_results_q.pop_front();
            if (got !== want) report("mismatch:", want, got);
         end
      end
   end

   // Abort when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put_item(input logic [7:0] b, input logic bv, input logic eom);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_wire_byte      <= b;
      req_byte_valid     <= bv;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall);
      decode_item(b, bv, eom);
      if (bv || eom) items_sent++;
   endtask

   // Drop valid, wait out every expected result and the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (tlv_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= AR_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ITEM_CAP) item_cap = value & 'h7F;
      else arena_cap = value & 'h1FFF;
      @(posedge clock);
   endtask

   task automatic set_caps(input int items, input int bytes);
      write_reg(CSR_ITEM_CAP, items);
      write_reg(CSR_ARENA_CAP, bytes);
   endtask

   task automatic test_single_records();
      gap_pct   = 6;
      stall_pct = 6;
      put_item(8'hA5, 1'b0, 1'b1);                  // empty message
      put_item(8'h5A, 1'b0, 1'b0);                  // idle, no result
      put_item(8'h00, 1'b1, 1'b0);
      put_item(8'h01, 1'b1, 1'b0);
      put_item(8'hFF, 1'b1, 1'b1);                  // last value byte closes
      put_item(TYPE_SEP, 1'b1, 1'b0);
      put_item(8'h00, 1'b1, 1'b0);
      put_item(8'hFE, 1'b1, 1'b0);
      put_item(8'h00, 1'b1, 1'b1);
      put_item(TYPE_SEP, 1'b1, 1'b0);               // separator carrying a length
      put_item(8'h01, 1'b1, 1'b0);
      put_item(8'h00, 1'b1, 1'b1);
      put_item(8'h05, 1'b1, 1'b1);                  // ends after type
      put_item(8'h07, 1'b1, 1'b0);
      put_item(8'h03, 1'b1, 1'b0);
      put_item(8'hAA, 1'b1, 1'b1);                  // ends inside value
      settle();
   endtask

   task automatic test_capacity();
      set_caps(64, 2);
      // capacity short, message ends inside the record
      put_item(8'h01, 1'b1, 1'b0);
      put_item(8'h03, 1'b1, 1'b0);
      put_item(8'h11, 1'b1, 1'b0);
      put_item(8'h22, 1'b1, 1'b1);
      put_item(8'h01, 1'b1, 1'b0);
      put_item(8'h03, 1'b1, 1'b0);
      put_item(8'h11, 1'b1, 1'b0);
      put_item(8'h22, 1'b1, 1'b0);
      put_item(8'h33, 1'b1, 1'b1);
      settle();
      write_reg(CSR_ARENA_CAP, 4);
      put_item(8'h02, 1'b1, 1'b0);
      put_item(8'h02, 1'b1, 1'b0);
      put_item(8'hA5, 1'b1, 1'b0);
      put_item(8'h5A, 1'b1, 1'b0);
      settle();
      // lower the store below what this message already used
      write_reg(CSR_ARENA_CAP, 1);
      put_item(8'h03, 1'b1, 1'b0);
      put_item(8'h01, 1'b1, 1'b0);
      put_item(8'h77, 1'b1, 1'b1);
      settle();
      write_reg(CSR_ARENA_CAP, ARENA_CAP_RST);
   endtask

   task automatic test_field_limit();
      int cap_choice;
      gap_pct   = 0;
      stall_pct = 0;
      for (cap_choice = 0; cap_choice < 3; cap_choice++) begin
         case (cap_choice)
            0: write_reg(CSR_ITEM_CAP, 64);
            1: write_reg(CSR_ITEM_CAP, 127);
            default: write_reg(CSR_ITEM_CAP, 0);
         endcase
         // zero-length records, one more than allowed when above the limit
         for (int i = 0; i < 64 + cap_choice; i++) begin
            put_item(8'($urandom_range(0, 254)), 1'b1, 1'b0);
            put_item(8'h00, 1'b1, i == 63 + cap_choice);
         end
         settle();
      end
      write_reg(CSR_ITEM_CAP, ITEM_CAP_RST);
   endtask

   task automatic test_join_and_overlength();
      gap_pct   = 0;
      stall_pct = 0;
      put_item(8'h07, 1'b1, 1'b0);
      put_item(LEN_FULL, 1'b1, 1'b0);
      repeat (255) put_item(8'($urandom), 1'b1, 1'b0);
      put_item(8'h07, 1'b1, 1'b0);                  // joins the full record
      put_item(8'd10, 1'b1, 1'b0);
      repeat (10) put_item(8'($urandom), 1'b1, 1'b0);
      put_item(TYPE_SEP, 1'b1, 1'b0);
      put_item(8'h00, 1'b1, 1'b0);
      put_item(8'h07, 1'b1, 1'b0);                  // separator forces a new field
      put_item(8'h01, 1'b1, 1'b0);
      put_item(8'h3C, 1'b1, 1'b1);
      // joined records running past the message length limit
      for (int r = 0; r < 16; r++) begin
         put_item(8'h5A, 1'b1, 1'b0);
         put_item(LEN_FULL, 1'b1, 1'b0);
         for (int i = 0; i < 255; i++) put_item(8'($urandom), 1'b1, r == 15 && i == 254);
      end
      settle();
   endtask

   task automatic send_random_message();
      logic [7:0] msg[$];
      logic [7:0] t;
      logic [7:0] last_type;
      bit         last_full;
      bit         close_apart;
      int         len;
      int         cut;
      last_type = 8'd0;
      last_full = 1'b0;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(99) < 8) begin
               msg.push_back(TYPE_SEP);
               msg.push_back(8'h00);
               last_full = 1'b0;
            end else begin
               t   = (last_full && $urandom_range(99) < 70) ? last_type
                                                              : 8'($urandom_range(0, 254));
               len = ($urandom_range(99) == 0) ? 255 : $urandom_range(0, 6);
               msg.push_back(t);
               msg.push_back(8'(len));
               repeat (len) msg.push_back(8'($urandom));
               last_type = t;
               last_full = (len == 255);
            end
         end
         // truncate now and then
         if (msg.size() > 0 && $urandom_range(99) < 10) begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut) void'(msg.pop_back());
         end
      end
      close_apart = (msg.size() == 0) || ($urandom_range(1) == 0);
      foreach (msg[i]) begin
         if ($urandom_range(99) < 5) put_item(8'($urandom), 1'b0, 1'b0);
         put_item(msg[i], 1'b1, (i == msg.size() - 1) && !close_apart);
      end
      if (close_apart) put_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_random();
      int gap_tab[4]   = '{0, 75, 0, 6};
      int stall_tab[4] = '{0, 0, 75, 6};
      int icap;
      int acap;
      int start;
      for (int p = 0; p < 4; p++) begin
         gap_pct   = gap_tab[p];
         stall_pct = stall_tab[p];
         for (int s = 0; s < 2; s++) begin
            settle();
            case (p * 2 + s)
               0: begin icap = 64;  acap = 4096; end
               1: begin icap = 2;   acap = 30;   end
               2: begin icap = 0;   acap = 4096; end
               3: begin icap = 127; acap = 8191; end
               4: begin icap = 5;   acap = 0;    end
               5: begin icap = $urandom_range(1, 10); acap = $urandom_range(1, 60); end
               6: begin icap = 64;  acap = 4096; end
               default: begin icap = $urandom_range(0, 64); acap = $urandom_range(0, 4096); end
            endcase
            set_caps(icap, acap);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_SLICE) send_random_message();
         end
      end
      settle();
   endtask

   initial begin
      clear_message();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_records();
      test_capacity();
      test_field_limit();
      test_join_and_overlength();
      test_random();
      if (err_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/tfj_pkg.sv
hw/rtl/tfj_csr.sv
hw/rtl/tfj_parse.sv
hw/rtl/tlv8_fragment_join_decoder_core.sv
bench/tb_tlv8_fragment_join_decoder_core.sv
